>>> rtl/core/rfcd_pkg.sv
// ----------------------------------------------------------------------------
// rfcd_pkg
// Shared types, constants and the CRC byte update of the remote frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rfcd_pkg;

  // Frame status codes.
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_CRC = 2'd1,
    STATUS_BAD_LEN = 2'd2
  } frame_status_t;

  // Reflected CRC-16 constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  // Raw channel width and decoded channel width.
  localparam int unsigned RAW_W  = 11;
  localparam int unsigned CHAN_W = 12;

  // Byte positions of the captured field bytes.
  localparam int unsigned FIELD_FIRST_BYTE = 2;
  localparam int unsigned FIELD_BYTES      = 8;
  localparam int unsigned KEY_LO_BYTE      = 17;
  localparam int unsigned KEY_HI_BYTE      = 18;

  // Decoded contents of one good frame.
  typedef struct packed {
    frame_status_t      status;
    logic [CHAN_W-1:0]  stick_0;
    logic [CHAN_W-1:0]  stick_1;
    logic [CHAN_W-1:0]  stick_2;
    logic [CHAN_W-1:0]  stick_3;
    logic [1:0]         mode_switch;
    logic               pause_button;
    logic               func_button_one;
    logic               func_button_two;
    logic [CHAN_W-1:0]  wheel_value;
    logic [15:0]        key_bits;
  } result_t;

  // One byte of the reflected CRC-16, bit by bit.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rfcd_field_decode.sv
// ----------------------------------------------------------------------------
// rfcd_field_decode
// Extracts the stick, switch, button, wheel and key fields of a frame and
// centres the channels on the configured offset.
// ----------------------------------------------------------------------------
`default_nettype none

module rfcd_field_decode (
  input  wire logic [63:0]                  field_word,  // frame bytes 2..9, byte 2 on top
  input  wire logic [15:0]                  key_word,
  input  wire logic [rfcd_pkg::RAW_W-1:0]   offset,
  input  wire rfcd_pkg::frame_status_t      status,
  output rfcd_pkg::result_t                 result
);

  // Raw channels, frame bit p sits at field_word[79 - p].
  logic [rfcd_pkg::RAW_W-1:0] raw_0, raw_1, raw_2, raw_3, raw_w;

  assign raw_0 = field_word[63:53];
  assign raw_1 = field_word[52:42];
  assign raw_2 = field_word[41:31];
  assign raw_3 = field_word[30:20];
  assign raw_w = field_word[14:4];

  // Centre a raw reading on the offset, two's complement result.
  function automatic logic [rfcd_pkg::CHAN_W-1:0] centre(
    input logic [rfcd_pkg::RAW_W-1:0] raw,
    input logic [rfcd_pkg::RAW_W-1:0] off
  );
    return {1'b0, raw} - {1'b0, off};
  endfunction

  // Fields are only reported for a good frame.
  always_comb begin
    result        = '0;
    result.status = status;
    if (status == rfcd_pkg::STATUS_OK) begin
      result.stick_0         = centre(raw_0, offset);
      result.stick_1         = centre(raw_1, offset);
      result.stick_2         = centre(raw_2, offset);
      result.stick_3         = centre(raw_3, offset);
      result.mode_switch     = field_word[19:18];
      result.pause_button    = field_word[17];
      result.func_button_one = field_word[16];
      result.func_button_two = field_word[15];
      result.wheel_value     = centre(raw_w, offset);
      result.key_bits        = key_word;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/remote_frame_crc_decoder.sv
// ----------------------------------------------------------------------------
// remote_frame_crc_decoder
// Checks the CRC-16 and length of a delimited remote-control frame and
// decodes its stick, switch, button, wheel and key fields.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle on the slave stream, with tlast on
// the final byte, and gives one result on the master stream for each frame.
// A byte is registered on entry; from the input register the byte-wide CRC
// update and the field capture are made, and the result is loaded into the
// output register as the final byte leaves the input register. Bytes may
// arrive back to back while a previous result waits to be taken; the input
// stalls only when a new frame ends while the output register is still full.
// Frames of other than FRAME_LEN bytes report wrong length, and all fields
// other than the status read zero unless it is ok. The user must write the
// channel offset via the cfg port only while idle; it is not enforced.
`default_nettype none

module remote_frame_crc_decoder #(
  parameter int unsigned FRAME_LEN = 21
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: channel_offset [10:0].
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data,
  // Input stream. tdata: rx_byte [7:0]. tlast: frame_end.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        s_tlast,
  // Output stream. tdata: stick_0 [11:0], stick_1 [23:12], stick_2 [35:24],
  // stick_3 [47:36], mode_switch [49:48], pause_button [50],
  // func_button_one [51], func_button_two [52], wheel_value [64:53],
  // key_bits [80:65], zero [87:81]. tuser: frame_status [1:0].
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata,
  output logic [1:0]       m_tuser
);

  localparam int unsigned CNT_W = $clog2(FRAME_LEN + 1);

  // Configuration register.
  logic [rfcd_pkg::RAW_W-1:0] channel_offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_offset <= 11'd1024;
    end else if (cfg_valid) begin
      channel_offset <= cfg_data;
    end
  end

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       in_advance;

  assign in_advance = in_valid && !(in_last && m_tvalid && !m_tready);
  assign s_tready   = !in_valid || in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Frame state: CRC, byte count and overlong mark.
  logic [15:0]      crc;
  logic [CNT_W-1:0] byte_count;
  logic             overlong;
  logic             can_store;

  assign can_store = byte_count < CNT_W'(FRAME_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc        <= rfcd_pkg::CRC_INIT;
      byte_count <= '0;
      overlong   <= 1'b0;
    end else if (in_advance) begin
      if (in_last) begin
        crc        <= rfcd_pkg::CRC_INIT;
        byte_count <= '0;
        overlong   <= 1'b0;
      end else if (can_store) begin
        if (byte_count < CNT_W'(FRAME_LEN - 2)) begin
          crc <= rfcd_pkg::crc_byte(crc, in_byte);
        end
        byte_count <= byte_count + 1'b1;
      end else begin
        overlong <= 1'b1;
      end
    end
  end

  // Capture of the bytes that carry fields, and of the previous byte.
  logic [7:0] field_bytes [rfcd_pkg::FIELD_BYTES];
  logic [7:0] key_lo;
  logic [7:0] key_hi;
  logic [7:0] prev_byte;

  always_ff @(posedge clk) begin
    if (in_advance && can_store) begin
      prev_byte <= in_byte;
      for (int i = 0; i < rfcd_pkg::FIELD_BYTES; i++) begin
        if (byte_count == CNT_W'(rfcd_pkg::FIELD_FIRST_BYTE + i)) begin
          field_bytes[i] <= in_byte;
        end
      end
      if (byte_count == CNT_W'(rfcd_pkg::KEY_LO_BYTE)) begin
        key_lo <= in_byte;
      end
      if (byte_count == CNT_W'(rfcd_pkg::KEY_HI_BYTE)) begin
        key_hi <= in_byte;
      end
    end
  end

  // Status of the frame that ends with the byte now in the input register.
  rfcd_pkg::frame_status_t status;

  always_comb begin
    priority if (overlong || byte_count != CNT_W'(FRAME_LEN - 1)) begin
      status = rfcd_pkg::STATUS_BAD_LEN;
    end else if (crc[7:0] != prev_byte || crc[15:8] != in_byte) begin
      status = rfcd_pkg::STATUS_BAD_CRC;
    end else begin
      status = rfcd_pkg::STATUS_OK;
    end
  end

  // Field decoding.
  logic [63:0]       field_word;
  rfcd_pkg::result_t decoded;

  always_comb begin
    for (int i = 0; i < rfcd_pkg::FIELD_BYTES; i++) begin
      field_word[63 - 8 * i -: 8] = field_bytes[i];
    end
  end

  rfcd_field_decode u_field_decode (
    .field_word (field_word),
    .key_word   ({key_hi, key_lo}),
    .offset     (channel_offset),
    .status     (status),
    .result     (decoded)
  );

  // Result register.
  rfcd_pkg::result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && in_last) begin
      result <= decoded;
    end
  end

  // Output packing.
  assign m_tuser = result.status;
  assign m_tdata = {7'd0,
                    result.key_bits,
                    result.wheel_value,
                    result.func_button_two,
                    result.func_button_one,
                    result.pause_button,
                    result.mode_switch,
                    result.stick_3,
                    result.stick_2,
                    result.stick_1,
                    result.stick_0};

endmodule

`default_nettype wire
